// ===== sv/csd_pkg.sv =====
// column separator detector package: item types, lane view, outcome codes
// and the candidate byte table
// no dependencies
package csd_pkg;

    localparam int NUM_CANDIDATES   = 5;
    localparam int COUNT_BITS       = 7;
    localparam int KNOWN_CANDIDATES = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] LINE_SEP_RESET = 8'd10;

    // tab, comma, semicolon, period, space in priority order (index 0 is tab)
    localparam logic [KNOWN_CANDIDATES-1:0][7:0] CAND_BYTES =
        {8'd32, 8'd46, 8'd59, 8'd44, 8'd9};

    localparam logic [1:0] OUTCOME_CONSISTENT = 2'd0;
    localparam logic [1:0] OUTCOME_MISMATCHED = 2'd1;
    localparam logic [1:0] OUTCOME_NONE       = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [7:0] chosen_separator;
        logic [1:0] outcome;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic clear;
        logic is_sep;
        logic awaiting;
    } t_lane_ctl;

    typedef struct packed {
        logic                  active;
        logic [7:0]            cand;
        logic [COUNT_BITS-1:0] ref_cnt;
        logic                  mismatch;
    } t_lane_view;

endpackage

// ===== sv/csd_lane.sv =====
// one candidate lane: per-line counter, reference count and mismatch flag
// depends on csd_pkg
module csd_lane
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_ctl  i_ctl,
    input  logic [7:0] i_text_byte,
    input  logic [7:0] i_line_sep,
    input  logic [7:0] i_cand_byte,
    input  logic       i_cand_known,
    output t_lane_view o_view
);

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] r_ref;
    logic                  r_mis;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] n_ref;
    logic                  n_mis;
    logic                  active;
    logic                  hit;

    assign active = i_cand_known && (i_cand_byte != i_line_sep);
    assign hit    = active && (i_text_byte == i_cand_byte);

    always_comb begin
        n_ref   = r_ref;
        n_mis   = r_mis;
        n_count = r_count;
        if (i_ctl.is_sep) begin
            if (i_ctl.awaiting) begin
                n_ref = r_count;
            end else if (r_count != r_ref) begin
                n_mis = 1'b1;
            end
            n_count = '0;
        end else if (hit && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            r_count <= '0;
            r_ref   <= '0;
            r_mis   <= 1'b0;
        end else if (i_ctl.step) begin
            r_count <= n_count;
            r_ref   <= n_ref;
            r_mis   <= n_mis;
        end
    end

    // selection sees the state as updated by the current item
    assign o_view.active   = active;
    assign o_view.cand     = i_cand_byte;
    assign o_view.ref_cnt  = n_ref;
    assign o_view.mismatch = n_mis;

endmodule

// ===== sv/csd_select.sv =====
// priority selection of the column separator from the lane views
// depends on csd_pkg
module csd_select
    import csd_pkg::*;
(
    input  t_lane_view i_view [NUM_CANDIDATES],
    output t_out_item  o_result
);

    always_comb begin
        logic done;
        done = 1'b0;
        o_result.chosen_separator = 8'd0;
        o_result.outcome          = OUTCOME_NONE;
        for (int j = 0; j < NUM_CANDIDATES; j++) begin
            if (!done && i_view[j].active && !i_view[j].mismatch
                    && (i_view[j].ref_cnt != '0)) begin
                o_result.chosen_separator = i_view[j].cand;
                o_result.outcome          = OUTCOME_CONSISTENT;
                done                      = 1'b1;
            end
        end
        for (int j = 0; j < NUM_CANDIDATES; j++) begin
            if (!done && i_view[j].active && i_view[j].mismatch) begin
                o_result.chosen_separator = i_view[j].cand;
                o_result.outcome          = OUTCOME_MISMATCHED;
                done                      = 1'b1;
            end
        end
    end

endmodule

// ===== sv/column_separator_detector.sv =====
// column separator detector top level: input register, candidate lanes,
// selection and result register; depends on csd_pkg, csd_lane, csd_select
// bytes of a text file enter on the input channel (i_in_valid, o_in_stall,
// i_in_item), one item per byte, the last byte flagged with is_final
// one result item leaves on the output channel (o_out_valid, i_out_stall,
// o_out_item) for each final byte; other bytes give no result
// the line separator register is written through i_cfg_wr_en and i_cfg_wr_data;
// the user writes it only while no file is in flight; the block does not enforce this
// throughput is one byte per cycle while no final byte waits on a stalled result:
// all lanes count and compare in parallel between the input and result registers
// a final byte accepted into the input register has its result written into
// the result register when the byte leaves the input register
// when the receiver stalls, the result register holds its item; the input
// register still takes non-final bytes, and a final byte waits there
// until the result register is free
// after each result all lane state is cleared for the next file; the
// line separator register keeps its value
// synchronous reset clears both registers' valid flags and all lane
// state, and sets the line separator to 10
module column_separator_detector
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    logic [7:0] r_line_sep_byte;
    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       r_awaiting;

    logic       advance;
    logic       step;
    logic       in_accept;
    logic       is_sep;
    t_lane_ctl  lane_ctl;
    t_lane_view lane_view [NUM_CANDIDATES];
    t_out_item  sel_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_sep_byte <= LINE_SEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_sep_byte <= i_cfg_wr_data;
        end
    end

    assign advance    = !r_in_item.is_final || !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_sep     = (r_in_item.text_byte == r_line_sep_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step && r_in_item.is_final)) begin
            r_awaiting <= 1'b1;
        end else if (step && is_sep) begin
            r_awaiting <= 1'b0;
        end
    end

    assign lane_ctl.step     = step;
    assign lane_ctl.clear    = r_in_item.is_final;
    assign lane_ctl.is_sep   = is_sep;
    assign lane_ctl.awaiting = r_awaiting;

    for (genvar g = 0; g < NUM_CANDIDATES; g++) begin : g_lane
        logic [7:0] cand_byte;
        logic       cand_known;
        if (g < KNOWN_CANDIDATES) begin : g_known
            assign cand_byte  = CAND_BYTES[g];
            assign cand_known = 1'b1;
        end else begin : g_spare
            assign cand_byte  = 8'd0;
            assign cand_known = 1'b0;
        end
        csd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (lane_ctl),
            .i_text_byte  (r_in_item.text_byte),
            .i_line_sep   (r_line_sep_byte),
            .i_cand_byte  (cand_byte),
            .i_cand_known (cand_known),
            .o_view       (lane_view[g])
        );
    end

    csd_select u_select (
        .i_view   (lane_view),
        .o_result (sel_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_item.is_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_item.is_final) begin
            r_out_item <= sel_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== verif/column_separator_detector_test.sv =====
// self-checking testbench for column_separator_detector: random text files with
// random gaps and stalls, results checked against a built-in prediction
// depends on csd_pkg and the column_separator_detector rtl
`timescale 1ns / 1ps

module column_separator_detector_test;
    import csd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 215;
    localparam int NUM_PHASES   = 9;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [NUM_PHASES-1:0][7:0] SEP_PLAN =
        {8'd10, 8'd10, 8'd46, 8'd59, 8'd32, 8'd9, 8'd44, 8'd255, 8'd0};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    column_separator_detector DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // predicted block state
    logic [7:0]            eol_byte = LINE_SEP_RESET;
    logic [COUNT_BITS-1:0] cur_count [NUM_CANDIDATES] = '{default: '0};
    logic [COUNT_BITS-1:0] first_count [NUM_CANDIDATES] = '{default: '0};
    logic                  broken [NUM_CANDIDATES] = '{default: 1'b0};
    logic                  first_line_open = 1'b1;

    t_in_item  pending_q [$];
    t_out_item separator_q [$];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  err_count = 0;
    int  in_blocked = 0;
    int  phase_bytes = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  gaps_on = 1'b1;
    bit  in_taken = 1'b0;

    function automatic bit lane_live(int j);
        return j < KNOWN_CANDIDATES && CAND_BYTES[j] != eol_byte;
    endfunction

    task automatic scan_byte(input t_in_item it);
        t_out_item res;
        bit        found;
        int        j;
        if (it.text_byte == eol_byte) begin
            for (j = 0; j < NUM_CANDIDATES; j++) begin
                if (first_line_open) begin
                    first_count[j] = cur_count[j];
                end else if (cur_count[j] != first_count[j]) begin
                    broken[j] = 1'b1;
                end
                cur_count[j] = '0;
            end
            first_line_open = 1'b0;
        end
        for (j = 0; j < NUM_CANDIDATES; j++) begin
            if (lane_live(j) && it.text_byte == CAND_BYTES[j]) begin
                if (cur_count[j] != COUNT_MAX) begin
                    cur_count[j] = cur_count[j] + COUNT_BITS'(1);
                end
                break;
            end
        end
        if (!it.is_final) begin
            return;
        end
        res.chosen_separator = 8'd0;
        res.outcome = OUTCOME_NONE;
        found = 1'b0;
        for (j = 0; j < NUM_CANDIDATES && !found; j++) begin
            if (lane_live(j) && !broken[j] && first_count[j] != '0) begin
                res.chosen_separator = CAND_BYTES[j];
                res.outcome = OUTCOME_CONSISTENT;
                found = 1'b1;
            end
        end
        for (j = 0; j < NUM_CANDIDATES && !found; j++) begin
            if (lane_live(j) && broken[j]) begin
                res.chosen_separator = CAND_BYTES[j];
                res.outcome = OUTCOME_MISMATCHED;
                found = 1'b1;
            end
        end
        separator_q.insert(separator_q.size(), res);
        for (j = 0; j < NUM_CANDIDATES; j++) begin
            cur_count[j] = '0;
            first_count[j] = '0;
            broken[j] = 1'b0;
        end
        first_line_open = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        err_count++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_item;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (pending_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 15)) begin
                nxt_item  = pending_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    // result receiver, with its own count for a long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= gaps_on && ($urandom_range(0, 99) < 15);
        end
    end

    // monitor: config tracking, result checks, accepted items into the prediction
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                eol_byte = i_cfg_wr_data;
            end
            if (o_out_valid && !i_out_stall) begin
                if (separator_q.size() == 0) begin
                    report_mismatch("result with nothing expected, separator",
                                    int'(o_out_item.chosen_separator), 0);
                end else begin
                    want = separator_q.pop_front();
                    if (o_out_item.chosen_separator !== want.chosen_separator) begin
                        report_mismatch("chosen_separator",
                                        int'(o_out_item.chosen_separator),
                                        int'(want.chosen_separator));
                    end
                    if (o_out_item.outcome !== want.outcome) begin
                        report_mismatch("outcome", int'(o_out_item.outcome),
                                        int'(want.outcome));
                    end
                    n_checked++;
                end
            end
            if (i_in_valid && o_in_stall) begin
                in_blocked++;
            end
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                n_accepted++;
                scan_byte(i_in_item);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic [7:0] b, input logic fin);
        t_in_item it;
        it.text_byte = b;
        it.is_final  = fin;
        pending_q.insert(pending_q.size(), it);
        n_queued++;
        phase_bytes++;
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            add_item(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_sep();
        int idx;
        idx = $urandom_range(0, KNOWN_CANDIDATES - 1);
        if (CAND_BYTES[idx] == eol_byte) begin
            idx = (idx + 1) % KNOWN_CANDIDATES;
        end
        return CAND_BYTES[idx];
    endfunction

    function automatic logic [7:0] field_char();
        logic [7:0] v;
        do begin
            v = $urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                     : 8'($urandom_range(48, 57));
        end while (v == eol_byte);
        return v;
    endfunction

    task automatic gen_file();
        int         kind;
        int         n_lines;
        int         n_cols;
        int         k;
        int         c;
        int         f;
        int         w;
        logic [7:0] sep;
        logic [7:0] tail;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            w = $urandom_range(1, 20);
            for (k = 0; k < w; k++) begin
                add_item(8'($urandom_range(0, 255)), k == w - 1);
            end
            return;
        end
        sep = pick_sep();
        if (kind < 13) begin
            // lines near the count limit, long enough to saturate the counts in some files
            for (k = 0; k < 2; k++) begin
                w = $urandom_range(120, 140);
                for (c = 0; c < w; c++) begin
                    add_item(sep, 1'b0);
                end
                add_item(eol_byte, 1'b0);
            end
            add_item(field_char(), 1'b1);
            return;
        end
        n_lines = $urandom_range(1, 5);
        n_cols  = $urandom_range(1, 6);
        for (k = 0; k < n_lines; k++) begin
            for (c = 0; c < n_cols; c++) begin
                if (c > 0) begin
                    add_item(sep, 1'b0);
                end
                w = $urandom_range(0, 4);
                for (f = 0; f < w; f++) begin
                    add_item(($urandom_range(0, 9) == 0) ? pick_sep() : field_char(), 1'b0);
                end
            end
            if (k < n_lines - 1 || $urandom_range(0, 2) != 0) begin
                add_item(eol_byte, 1'b0);
            end
        end
        case ($urandom_range(0, 2))
            0: tail = eol_byte;
            1: tail = sep;
            default: tail = field_char();
        endcase
        add_item(tail, 1'b1);
    endtask

    task automatic wait_idle();
        while (!(n_accepted == n_queued && separator_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_sep(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_text("a,b\nc,d\n");
        queue_text(";\n\n");
        queue_text("a.b");
        queue_text("\t \nz");
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b1);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_line_sep((p == 7) ? 8'($urandom_range(0, 255)) : SEP_PLAN[p]);
            gaps_on = (p != 4);
            if (p == 2) begin
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                gen_file();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d bytes and %0d files under %0d line separator settings",
                 n_accepted, n_checked, NUM_PHASES + 1);
        $display("input held off for %0d cycles by a full pipeline, %0d mismatches",
                 in_blocked, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/csd_pkg.sv
sv/csd_lane.sv
sv/csd_select.sv
sv/column_separator_detector.sv
verif/column_separator_detector_test.sv
